@@ rtl/core/focus_window_work_scheduler_assert.svh @@
// Assertion macros shared by the scheduler checker
`ifndef FOCUS_WINDOW_WORK_SCHEDULER_ASSERT_SVH
`define FOCUS_WINDOW_WORK_SCHEDULER_ASSERT_SVH

// Check a property on every clock edge outside reset
`define FWS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define FWS_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/fws_pkg.sv @@
// Shared types and constants of the focus window work scheduler
package fws_pkg;

    localparam int PAGE_W  = 12;
    localparam int TOTAL_W = 13;
    localparam int CALC_W  = 18;
    localparam int D_W     = 13;
    localparam int XW      = 17;
    localparam int MAP_FULL  = 1;
    localparam int MAP_THUMB = 0;

    typedef enum logic [1:0] {
        OP_FOCUS      = 2'd0,
        OP_NEXT       = 2'd1,
        OP_MARK_FULL  = 2'd2,
        OP_MARK_THUMB = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CALC, S_FCHK, S_FHI, S_FLO, S_MARK_F,
        S_THUMB_RD, S_THUMB_WR, S_PRIO, S_PRIO_LIST, S_PRIO_MAP, S_BG, S_BG_CHK
    } t_state;

    typedef struct packed {
        logic clr_done;
        logic repeat_focus;
        logic gen_done;
        logic entry_full;
        logic prio_avail;
        logic bg_avail;
        logic bg_free;
        logic out_busy;
    } t_sts;

    typedef struct packed {
        logic load_in;
        logic clr_step;
        logic calc;
        logic focus_begin;
        logic push_hi;
        logic push_lo;
        logic mark_full;
        logic thumb_rd;
        logic thumb_wr;
        logic prio_rd;
        logic prio_pop;
        logic prio_clear;
        logic bg_rd;
        logic emit_prio;
        logic emit_bg;
        logic emit_none;
    } t_cmd;

endpackage

@@ rtl/core/fws_ram.sv @@
// Generic single write port RAM with registered read
module fws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/fws_ctrl.sv @@
// Control state machine of the scheduler
module fws_ctrl
    import fws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // sequence each word
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    case (t_op'(i_opcode))
                        OP_FOCUS:     n_state = S_CALC;
                        OP_NEXT:      n_state = S_PRIO;
                        OP_MARK_FULL: n_state = S_MARK_F;
                        default:      n_state = S_THUMB_RD;
                    endcase
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (i_sts.repeat_focus) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.focus_begin = 1'b1;
                    n_state = S_FHI;
                end
            end
            S_FHI: begin
                if (i_sts.gen_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.push_hi = 1'b1;
                    n_state = S_FLO;
                end
            end
            S_FLO: begin
                o_cmd.push_lo = 1'b1;
                n_state = S_FHI;
            end
            S_MARK_F: begin
                o_cmd.mark_full = 1'b1;
                n_state = S_IDLE;
            end
            S_THUMB_RD: begin
                o_cmd.thumb_rd = 1'b1;
                n_state = S_THUMB_WR;
            end
            S_THUMB_WR: begin
                o_cmd.thumb_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_PRIO: begin
                if (i_sts.prio_avail) begin
                    o_cmd.prio_rd = 1'b1;
                    n_state = S_PRIO_LIST;
                end else begin
                    o_cmd.prio_clear = 1'b1;
                    n_state = S_BG;
                end
            end
            S_PRIO_LIST: begin
                o_cmd.prio_pop = 1'b1;
                n_state = S_PRIO_MAP;
            end
            S_PRIO_MAP: begin
                if (i_sts.entry_full) begin
                    n_state = S_PRIO;
                end else if (!i_sts.out_busy) begin
                    o_cmd.emit_prio = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BG: begin
                if (i_sts.bg_avail) begin
                    o_cmd.bg_rd = 1'b1;
                    n_state = S_BG_CHK;
                end else if (!i_sts.out_busy) begin
                    o_cmd.emit_none = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_BG_CHK: begin
                if (!i_sts.bg_free) begin
                    n_state = S_BG;
                end else if (!i_sts.out_busy) begin
                    o_cmd.emit_bg = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

@@ rtl/core/fws_dp.sv @@
// Datapath of the scheduler: bitmaps, priority list, cursor, output word
module fws_dp
    import fws_pkg::*;
#(
    parameter int MAX_PAGES    = 4096,
    parameter int MAX_PRIORITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_valid,
    input  logic [TOTAL_W-1:0] i_cfg_total_pages,
    input  logic [PAGE_W-1:0]  i_page,
    input  logic [PAGE_W-1:0]  i_window_before,
    input  logic [PAGE_W-1:0]  i_window_after,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [PAGE_W-1:0]  o_page_index,
    output logic               o_needs_page,
    output logic               o_none_pending
);
    localparam int AW = $clog2(MAX_PAGES);
    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int PW = (MAX_PRIORITY > 1) ? $clog2(MAX_PRIORITY) : 1;
    localparam int NW = $clog2(MAX_PRIORITY + 1);
    localparam int EW = (CW > TOTAL_W) ? CW : TOTAL_W;

    logic [TOTAL_W-1:0] r_total;
    logic [PAGE_W-1:0]  r_page, r_wb, r_wa, r_start, r_span, r_pg;
    logic               r_pg_ok;
    logic signed [13:0] r_end, r_last_c, r_last_s, r_last_e;
    logic [D_W-1:0]     r_d;
    logic [NW-1:0]      r_head, r_count;
    logic [CW-1:0]      r_cursor, eff_total;
    logic [AW-1:0]      r_clr_addr;
    logic               r_out_valid, r_needs, r_none;
    logic [PAGE_W-1:0]  r_out_page;

    logic [EW-1:0]         total_x, max_x;
    logic signed [13:0]    st_raw, en_raw, end_sel14;
    logic signed [CALC_W-1:0] lim, en_x, end_sel;
    logic [PAGE_W-1:0]     start_c;
    logic signed [14:0]    span_a, span_b, hi_p, lo_p;
    logic                  hi_ok, lo_ok, page_ok, count_full;
    logic                  list_we;
    logic [PW-1:0]         list_waddr;
    logic [PAGE_W-1:0]     list_wdata, list_rdata;
    logic                  map_we, map_re;
    logic [AW-1:0]         map_waddr, map_raddr;
    logic [1:0]            map_wdata, map_rdata;

    // clip the total to the bitmap size
    assign total_x   = EW'(r_total);
    assign max_x     = EW'(MAX_PAGES);
    assign eff_total = CW'((total_x >= max_x) ? max_x : total_x);

    // window bounds of the latched focus word
    assign st_raw    = $signed({2'b00, r_page}) - $signed({2'b00, r_wb});
    assign start_c   = (st_raw < 0) ? '0 : st_raw[PAGE_W-1:0];
    assign en_raw    = $signed({2'b00, r_page}) + $signed({2'b00, r_wa});
    assign lim       = $signed(CALC_W'(eff_total)) - 18'sd1;
    assign en_x      = CALC_W'(en_raw);
    assign end_sel   = (en_x > lim) ? lim : en_x;
    assign end_sel14 = end_sel[13:0];
    assign span_a    = $signed({3'b000, r_page}) - $signed({3'b000, start_c});
    assign span_b    = $signed({end_sel14[13], end_sel14}) - $signed({3'b000, r_page});

    // candidate pages at distance d
    assign hi_p       = $signed({3'b000, r_page}) + $signed({2'b00, r_d});
    assign lo_p       = $signed({3'b000, r_page}) - $signed({2'b00, r_d});
    assign count_full = (r_count == NW'(MAX_PRIORITY));
    assign hi_ok      = (hi_p <= $signed({r_end[13], r_end})) && !count_full;
    assign lo_ok      = (lo_p >= $signed({3'b000, r_start})) && !count_full;
    assign page_ok    = (XW'(r_page) < XW'(MAX_PAGES));

    // status back to the controller
    assign o_sts.clr_done     = (r_clr_addr == AW'(MAX_PAGES - 1));
    assign o_sts.repeat_focus = ($signed({2'b00, r_page}) == r_last_c)
                             && ($signed({2'b00, r_start}) == r_last_s)
                             && (r_end == r_last_e);
    assign o_sts.gen_done     = (r_d > D_W'(r_span)) || count_full;
    assign o_sts.entry_full   = r_pg_ok && map_rdata[MAP_FULL];
    assign o_sts.prio_avail   = (r_count != '0) && (r_head < NW'(MAX_PRIORITY));
    assign o_sts.bg_avail     = (r_cursor < eff_total);
    assign o_sts.bg_free      = !map_rdata[MAP_FULL] && !map_rdata[MAP_THUMB];
    assign o_sts.out_busy     = r_out_valid && !i_out_ready;

    // priority list writes
    always_comb begin
        list_we    = 1'b0;
        list_waddr = r_count[PW-1:0];
        list_wdata = r_page;
        if (i_cmd.focus_begin) begin
            list_we    = 1'b1;
            list_waddr = '0;
        end else if (i_cmd.push_hi) begin
            list_we    = hi_ok;
            list_wdata = hi_p[PAGE_W-1:0];
        end else if (i_cmd.push_lo) begin
            list_we    = lo_ok;
            list_wdata = lo_p[PAGE_W-1:0];
        end
    end

    fws_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PRIORITY)) u_list (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_re    (i_cmd.prio_rd),
        .i_raddr (r_head[PW-1:0]),
        .o_rdata (list_rdata)
    );

    // bitmap port selection
    always_comb begin
        map_we    = 1'b0;
        map_waddr = AW'(r_page);
        map_wdata = 2'b00;
        if (i_cmd.clr_step) begin
            map_we    = 1'b1;
            map_waddr = r_clr_addr;
        end else if (i_cmd.mark_full) begin
            map_we    = page_ok;
            map_wdata = 2'b10;
        end else if (i_cmd.thumb_wr) begin
            map_we    = page_ok && !map_rdata[MAP_FULL];
            map_wdata = 2'b01;
        end
        map_re    = i_cmd.thumb_rd || i_cmd.prio_pop || i_cmd.bg_rd;
        map_raddr = AW'(r_page);
        if (i_cmd.prio_pop) begin
            map_raddr = AW'(list_rdata);
        end else if (i_cmd.bg_rd) begin
            map_raddr = r_cursor[AW-1:0];
        end
    end

    fws_ram #(.WIDTH(2), .DEPTH(MAX_PAGES)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // latch the input word and focus bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_page <= i_page;
            r_wb   <= i_window_before;
            r_wa   <= i_window_after;
        end
        if (i_cmd.calc) begin
            r_start <= start_c;
            r_end   <= end_sel14;
            r_span  <= (span_b > span_a) ? span_b[PAGE_W-1:0] : span_a[PAGE_W-1:0];
        end
        if (i_cmd.prio_pop) begin
            r_pg    <= list_rdata;
            r_pg_ok <= (XW'(list_rdata) < XW'(MAX_PAGES));
        end else if (i_cmd.bg_rd) begin
            r_pg    <= PAGE_W'(r_cursor);
            r_pg_ok <= 1'b1;
        end
        if (i_cmd.focus_begin) begin
            r_d <= D_W'(1);
        end else if (i_cmd.push_lo) begin
            r_d <= r_d + D_W'(1);
        end
        if (i_cmd.emit_prio || i_cmd.emit_bg || i_cmd.emit_none) begin
            r_out_page <= i_cmd.emit_none ? '0 : r_pg;
            r_needs    <= i_cmd.emit_prio;
            r_none     <= i_cmd.emit_none;
        end
    end

    // advance control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_cursor    <= '0;
            r_clr_addr  <= '0;
            r_last_c    <= -14'sd1;
            r_last_s    <= -14'sd1;
            r_last_e    <= -14'sd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_total <= i_cfg_total_pages;
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cmd.focus_begin) begin
                r_head   <= '0;
                r_count  <= NW'(1);
                r_last_c <= $signed({2'b00, r_page});
                r_last_s <= $signed({2'b00, r_start});
                r_last_e <= r_end;
            end else if ((i_cmd.push_hi && hi_ok) || (i_cmd.push_lo && lo_ok)) begin
                r_count <= r_count + NW'(1);
            end else if (i_cmd.prio_pop) begin
                r_head  <= r_head + NW'(1);
                r_count <= r_count - NW'(1);
            end else if (i_cmd.prio_clear) begin
                r_count <= '0;
            end
            if (i_cmd.bg_rd) r_cursor <= r_cursor + CW'(1);
            if (i_cmd.emit_prio || i_cmd.emit_bg || i_cmd.emit_none) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_page_index   = r_out_page;
    assign o_needs_page   = r_needs;
    assign o_none_pending = r_none;
endmodule

@@ rtl/core/focus_window_work_scheduler.sv @@
// Focus queues the focus page, then pages outward from it; marks write the bitmap.
// Next pops queued pages, skipping full ones, then scans for a free page, or reports none.
// A result waits in an output register; the next word is taken meanwhile.
// Words are handled one at a time: a new word is taken only in the idle state.
// Reset: synchronous; a clearing pass over every bitmap address then runs, no word taken.
// Configuration writes are taken in every cycle outside reset.
module focus_window_work_scheduler
    import fws_pkg::*;
#(
    parameter int MAX_PAGES    = 4096,
    parameter int MAX_PRIORITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [TOTAL_W-1:0] i_cfg_total_pages,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [PAGE_W-1:0]  i_page,
    input  logic [PAGE_W-1:0]  i_window_before,
    input  logic [PAGE_W-1:0]  i_window_after,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [PAGE_W-1:0]  o_page_index,
    output logic               o_needs_page,
    output logic               o_none_pending
);
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    fws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    fws_dp #(.MAX_PAGES(MAX_PAGES), .MAX_PRIORITY(MAX_PRIORITY)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_total_pages (i_cfg_total_pages),
        .i_page            (i_page),
        .i_window_before   (i_window_before),
        .i_window_after    (i_window_after),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_page_index      (o_page_index),
        .o_needs_page      (o_needs_page),
        .o_none_pending    (o_none_pending)
    );
endmodule

@@ rtl/core/fws_checker.sv @@
// Port level checks of the scheduler and their bind
`include "focus_window_work_scheduler_assert.svh"
module fws_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [11:0] o_page_index,
    input logic        o_needs_page,
    input logic        o_none_pending
);
    // hold a stalled result word
    `FWS_ASSERT_RST(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_page_index) && $stable(o_none_pending), "result word dropped while stalled")
    // an empty report carries no page
    `FWS_ASSERT_RST(a_none_clean, o_out_valid && o_none_pending |-> o_page_index == 12'd0 && !o_needs_page, "none pending word carries a page")
    // drop ready after taking a word
    `FWS_ASSERT_RST(a_busy_after_accept, i_in_valid && o_in_ready |=> !o_in_ready, "second word taken while busy")
    // stay quiet after reset
    `FWS_ASSERT_ANY(a_reset_quiet, !i_rst_n |=> !o_out_valid && !o_in_ready, "activity right after reset")
endmodule

bind focus_window_work_scheduler fws_checker u_fws_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_page_index   (o_page_index),
    .o_needs_page   (o_needs_page),
    .o_none_pending (o_none_pending)
);
